[sv/rtnp_pkg.sv]
package rtnp_pkg;

  localparam int CHAR_W     = 8;
  localparam int FREQ_W     = 14;
  localparam int DUR_W      = 23;
  localparam int WNT_W      = 22;
  localparam int DURNUM_W   = 8;
  localparam int OCT_W      = 4;
  localparam int BASE_W     = 10;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_WNT_ADDR = CFG_ADDR_W'(0);
  localparam logic [WNT_W-1:0]      WNT_RESET    = WNT_W'(2000000);

  localparam logic [DURNUM_W-1:0] DEF_DUR_RESET = DURNUM_W'(4);
  localparam logic [OCT_W-1:0]    DEF_OCT_RESET = OCT_W'(6);
  localparam logic [OCT_W-1:0]    OCT_MAX       = OCT_W'(9);
  localparam logic [OCT_W-1:0]    OCT_BASE      = OCT_W'(5);

  localparam logic [FREQ_W-1:0] FREQ_MIN = FREQ_W'(440);
  localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(13280);

  typedef struct packed {
    logic zero;
    logic colon;
    logic comma;
    logic hash;
    logic dot;
    logic digit;
    logic lower;
  } chr_class_t;

  typedef struct packed {
    chr_class_t cls;
    logic       div_done;
  } dp_status_t;

  typedef struct packed {
    logic clear_all;
    logic key_load;
    logic acc_digit;
    logic def_commit;
    logic note_init;
    logic dur_first;
    logic dur_second;
    logic letter_set;
    logic sharp_set;
    logic dot_set;
    logic oct_set;
    logic note_end;
    logic out_load;
  } dp_cmd_t;

  // Base frequencies of a to g, and their sharpened values scaled by 10595/10000.
  function automatic logic [BASE_W-1:0] tone_freq(input logic [2:0] idx, input logic sharp);
    logic [BASE_W-1:0] f;
    case ({sharp, idx})
      4'h1: f = BASE_W'(440);
      4'h2: f = BASE_W'(494);
      4'h3: f = BASE_W'(523);
      4'h4: f = BASE_W'(587);
      4'h5: f = BASE_W'(659);
      4'h6: f = BASE_W'(698);
      4'h7: f = BASE_W'(784);
      4'h9: f = BASE_W'(466);
      4'hA: f = BASE_W'(523);
      4'hB: f = BASE_W'(554);
      4'hC: f = BASE_W'(621);
      4'hD: f = BASE_W'(698);
      4'hE: f = BASE_W'(739);
      4'hF: f = BASE_W'(830);
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

[sv/rtnp_char_if.sv]
interface rtnp_char_if import rtnp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

[sv/rtnp_note_if.sv]
interface rtnp_note_if import rtnp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency_hz;
  logic [DUR_W-1:0]  note_duration;
  logic              last_note;

  modport source (output valid, output frequency_hz, output note_duration, output last_note,
                  input ready);
  modport sink (input valid, input frequency_hz, input note_duration, input last_note,
                output ready);
endinterface

[sv/rtnp_div.sv]
module rtnp_div import rtnp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [WNT_W-1:0]    dividend,
  input  logic [DURNUM_W-1:0] divisor,
  output logic                done,
  output logic [WNT_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(WNT_W);

  logic [WNT_W-1:0]    quo;
  logic [DURNUM_W-1:0] rem;
  logic [DURNUM_W-1:0] dvs;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                zero_div;
  logic [DURNUM_W:0]   trial;
  logic [DURNUM_W:0]   diff;
  logic                fits;

  assign trial = {rem, quo[WNT_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo      <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= CNT_W'(WNT_W - 1);
      zero_div <= (divisor == '0);
    end else if (busy) begin
      quo <= {quo[WNT_W-2:0], fits};
      rem <= fits ? diff[DURNUM_W-1:0] : trial[DURNUM_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient = zero_div ? '0 : quo;

endmodule

[sv/rtnp_ctrl.sv]
module rtnp_ctrl import rtnp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] PH_TITLE  = 4'd0;
  localparam logic [3:0] PH_DEFKEY = 4'd1;
  localparam logic [3:0] PH_DEFVAL = 4'd2;
  localparam logic [3:0] PH_START  = 4'd3;
  localparam logic [3:0] PH_DUR1   = 4'd4;
  localparam logic [3:0] PH_DUR2   = 4'd5;
  localparam logic [3:0] PH_LETTER = 4'd6;
  localparam logic [3:0] PH_SHARP  = 4'd7;
  localparam logic [3:0] PH_DOT    = 4'd8;
  localparam logic [3:0] PH_OCT    = 4'd9;
  localparam logic [3:0] PH_SEP    = 4'd10;

  localparam logic SEQ_IDLE = 1'b0;
  localparam logic SEQ_DIV  = 1'b1;

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic       seq;
  logic       seq_next;
  logic       out_valid_next;
  logic       accept;
  logic       note_tail;
  logic       out_load;
  dp_cmd_t    cmd_phase;
  chr_class_t cls;

  assign cls      = status.cls;
  assign in_ready = (seq == SEQ_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next = phase;
    cmd_phase  = '0;
    note_tail  = 1'b0;
    if (accept) begin
      case (phase)
        PH_TITLE: begin
          if (cls.zero) cmd_phase.clear_all = 1'b1;
          else if (cls.colon) phase_next = PH_DEFKEY;
        end
        PH_DEFKEY: begin
          if (cls.zero) cmd_phase.clear_all = 1'b1;
          else if (cls.colon) phase_next = PH_START;
          else if (cls.lower) begin
            cmd_phase.key_load = 1'b1;
            phase_next         = PH_DEFVAL;
          end
        end
        PH_DEFVAL: begin
          if (cls.zero) cmd_phase.clear_all = 1'b1;
          else if (cls.digit) cmd_phase.acc_digit = 1'b1;
          else if (cls.colon || cls.comma) begin
            cmd_phase.def_commit = 1'b1;
            phase_next           = cls.colon ? PH_START : PH_DEFKEY;
          end
        end
        PH_START, PH_DUR1: begin
          cmd_phase.note_init = (phase == PH_START);
          if (cls.zero) cmd_phase.clear_all = 1'b1;
          else if (cls.digit) begin
            cmd_phase.dur_first = 1'b1;
            phase_next          = PH_DUR2;
          end else begin
            cmd_phase.letter_set = 1'b1;
            phase_next           = PH_SHARP;
          end
        end
        PH_DUR2: begin
          if (cls.digit) begin
            cmd_phase.dur_second = 1'b1;
            phase_next           = PH_LETTER;
          end else if (cls.zero) cmd_phase.clear_all = 1'b1;
          else begin
            cmd_phase.letter_set = 1'b1;
            phase_next           = PH_SHARP;
          end
        end
        PH_LETTER: begin
          if (cls.zero) cmd_phase.clear_all = 1'b1;
          else begin
            cmd_phase.letter_set = 1'b1;
            phase_next           = PH_SHARP;
          end
        end
        PH_SHARP: begin
          if (cls.hash) begin
            cmd_phase.sharp_set = 1'b1;
            phase_next          = PH_DOT;
          end else if (cls.dot) begin
            cmd_phase.dot_set = 1'b1;
            phase_next        = PH_OCT;
          end else if (cls.digit) begin
            cmd_phase.oct_set = 1'b1;
            phase_next        = PH_SEP;
          end else note_tail = 1'b1;
        end
        PH_DOT: begin
          if (cls.dot) begin
            cmd_phase.dot_set = 1'b1;
            phase_next        = PH_OCT;
          end else if (cls.digit) begin
            cmd_phase.oct_set = 1'b1;
            phase_next        = PH_SEP;
          end else note_tail = 1'b1;
        end
        PH_OCT: begin
          if (cls.digit) begin
            cmd_phase.oct_set = 1'b1;
            phase_next        = PH_SEP;
          end else note_tail = 1'b1;
        end
        PH_SEP: note_tail = 1'b1;
        default: cmd_phase.clear_all = 1'b1;
      endcase
      if (note_tail && (cls.comma || cls.zero)) begin
        cmd_phase.note_end  = 1'b1;
        cmd_phase.clear_all = cls.zero;
        phase_next          = PH_START;
      end
      if (cmd_phase.clear_all) phase_next = PH_TITLE;
    end
  end

  always_comb begin
    seq_next = seq;
    out_load = 1'b0;
    case (seq)
      SEQ_IDLE: if (cmd_phase.note_end) seq_next = SEQ_DIV;
      SEQ_DIV: begin
        if (status.div_done && (!out_valid || out_ready)) begin
          out_load = 1'b1;
          seq_next = SEQ_IDLE;
        end
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    cmd          = cmd_phase;
    cmd.out_load = out_load;
  end

  assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TITLE;
      seq       <= SEQ_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      seq       <= seq_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[sv/rtnp_datapath.sv]
module rtnp_datapath import rtnp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [WNT_W-1:0]  whole_note_time,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output logic [FREQ_W-1:0] frequency_hz,
  output logic [DUR_W-1:0]  note_duration,
  output logic              last_note
);

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_D  = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LOW_G  = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LOW_O  = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;

  localparam logic [1:0] KEY_OTHER = 2'd0;
  localparam logic [1:0] KEY_DUR   = 2'd1;
  localparam logic [1:0] KEY_OCT   = 2'd2;

  localparam int NUM_W   = DURNUM_W + 4;
  localparam int FWIDE_W = BASE_W + 2**OCT_W;

  chr_class_t cls;
  logic       is_ag;
  logic [3:0] digit;

  logic [DURNUM_W-1:0] default_duration;
  logic [OCT_W-1:0]    default_octave;
  logic [1:0]          default_key;
  logic [DURNUM_W-1:0] acc;
  logic [DURNUM_W-1:0] cur_dur;
  logic [OCT_W-1:0]    cur_oct;
  logic [2:0]          note_idx;
  logic                sharp;
  logic                dotted;

  logic [FREQ_W-1:0] pend_freq;
  logic              pend_dot;
  logic              pend_last;

  logic [NUM_W-1:0]   acc_wide;
  logic [NUM_W-1:0]   dur_wide;
  logic [BASE_W-1:0]  base_freq;
  logic [OCT_W-1:0]   shamt;
  logic [FWIDE_W-1:0] freq_wide;
  logic               div_done;
  logic [WNT_W-1:0]   quotient;
  logic [DUR_W:0]     triple;

  assign cls.zero  = (char_code == CH_NUL);
  assign cls.colon = (char_code == CH_COLON);
  assign cls.comma = (char_code == CH_COMMA);
  assign cls.hash  = (char_code == CH_HASH);
  assign cls.dot   = (char_code == CH_DOT);
  assign cls.digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign cls.lower = (char_code >= CH_LOW_A) && (char_code <= CH_LOW_Z);
  assign is_ag     = (char_code >= CH_LOW_A) && (char_code <= CH_LOW_G);
  assign digit     = char_code[3:0];

  assign status.cls      = cls;
  assign status.div_done = div_done;

  assign acc_wide = NUM_W'(acc) * NUM_W'(10) + NUM_W'(digit);
  assign dur_wide = NUM_W'(cur_dur) * NUM_W'(10) + NUM_W'(digit);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      default_duration <= DEF_DUR_RESET;
      default_octave   <= DEF_OCT_RESET;
      default_key      <= KEY_OTHER;
      acc              <= '0;
      cur_dur          <= '0;
      cur_oct          <= '0;
      note_idx         <= '0;
      sharp            <= 1'b0;
      dotted           <= 1'b0;
    end else begin
      if (cmd.key_load) begin
        acc <= '0;
        if (char_code == CH_LOW_O) default_key <= KEY_OCT;
        else if (char_code == CH_LOW_D) default_key <= KEY_DUR;
        else default_key <= KEY_OTHER;
      end
      if (cmd.acc_digit) begin
        acc <= (acc_wide > NUM_W'(255)) ? '1 : acc_wide[DURNUM_W-1:0];
      end
      if (cmd.def_commit) begin
        if (default_key == KEY_OCT) begin
          default_octave <= (acc > DURNUM_W'(OCT_MAX)) ? OCT_MAX : acc[OCT_W-1:0];
        end else if (default_key == KEY_DUR) begin
          default_duration <= acc;
        end
      end
      if (cmd.note_init) begin
        cur_dur  <= default_duration;
        cur_oct  <= default_octave;
        dotted   <= 1'b0;
        note_idx <= '0;
        sharp    <= 1'b0;
      end
      if (cmd.dur_first) cur_dur <= DURNUM_W'(digit);
      if (cmd.dur_second) cur_dur <= dur_wide[DURNUM_W-1:0];
      if (cmd.letter_set) begin
        note_idx <= is_ag ? char_code[2:0] : 3'd0;
        sharp    <= 1'b0;
      end
      if (cmd.sharp_set) sharp <= 1'b1;
      if (cmd.dot_set) dotted <= 1'b1;
      if (cmd.oct_set) cur_oct <= digit;
    end
  end

  // Octaves above the base one double the frequency; the result keeps its low bits.
  assign base_freq = tone_freq(note_idx, sharp);
  assign shamt     = (cur_oct > OCT_BASE) ? cur_oct - OCT_BASE : '0;
  assign freq_wide = FWIDE_W'(base_freq) << shamt;

  always_ff @(posedge clk) begin
    if (cmd.note_end) begin
      pend_freq <= freq_wide[FREQ_W-1:0];
      pend_dot  <= dotted;
      pend_last <= cls.zero;
    end
  end

  rtnp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.note_end),
    .dividend (whole_note_time),
    .divisor  (cur_dur),
    .done     (div_done),
    .quotient (quotient)
  );

  assign triple = (DUR_W+1)'(quotient) + (DUR_W+1)'({quotient, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frequency_hz  <= pend_freq;
      note_duration <= pend_dot ? triple[DUR_W:1] : DUR_W'(quotient);
      last_note     <= pend_last;
    end
  end

endmodule

[sv/ringtone_text_note_parser.sv]
// A character that completes a note starts the duration divider, whose 22 iterations
// give the duration; input is not taken until the note reaches the output register.
// Every other character is taken while no divide is pending and yields no result.
// A finished note waits in the output register while the next characters are taken.
// Synchronous active-high reset returns the parser to the title phase, clears the output valid
// and sets the whole-note time to 2000000.
module ringtone_text_note_parser import rtnp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  rtnp_char_if.sink             char_in,
  rtnp_note_if.source           note_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WNT_W-1:0] whole_note_time;
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             in_ready;
  logic             out_valid;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      whole_note_time <= WNT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_WNT_ADDR) begin
      whole_note_time <= pwdata[WNT_W-1:0];
    end
  end

  assign prdata = (paddr == REG_WNT_ADDR) ? CFG_DATA_W'(whole_note_time) : '0;

  rtnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (char_in.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (note_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rtnp_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .char_code       (char_in.char_code),
    .whole_note_time (whole_note_time),
    .cmd             (cmd),
    .status          (status),
    .frequency_hz    (note_out.frequency_hz),
    .note_duration   (note_out.note_duration),
    .last_note       (note_out.last_note)
  );

  assign char_in.ready  = in_ready;
  assign note_out.valid = out_valid;

endmodule

[sv/rtnp_checker.sv]
module rtnp_checker import rtnp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FREQ_W-1:0] frequency_hz,
  input logic [DUR_W-1:0]  note_duration,
  input logic              last_note
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frequency_hz)
      && $stable(note_duration) && $stable(last_note))
    else $error("Stalled output transaction changed.");

  a_freq_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frequency_hz == '0)
      || (frequency_hz >= FREQ_MIN && frequency_hz <= FREQ_MAX))
    else $error("Output frequency outside the reachable range.");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("Result appeared without a preceding divide.");

  a_busy_after_input: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("Input stalled without a preceding transaction.");

endmodule

bind ringtone_text_note_parser rtnp_checker u_rtnp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (char_in.valid),
  .in_ready      (char_in.ready),
  .out_valid     (note_out.valid),
  .out_ready     (note_out.ready),
  .frequency_hz  (note_out.frequency_hz),
  .note_duration (note_out.note_duration),
  .last_note     (note_out.last_note)
);

[verif/tb_ringtone_text_note_parser.sv]
`timescale 1ns / 1ps

module tb_ringtone_text_note_parser import rtnp_pkg::*; ();

  localparam int IDLE_LIMIT             = 1000;
  localparam int SETTLE_CYCLES          = 30;
  localparam int RANDOM_CHARS_PER_PHASE = 120;

  localparam logic [CHAR_W-1:0] CH_END     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SHARP   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DIGIT0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT9  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_A       = 8'h61;
  localparam logic [CHAR_W-1:0] CH_KEY_BPM = 8'h62;
  localparam logic [CHAR_W-1:0] CH_KEY_DUR = 8'h64;
  localparam logic [CHAR_W-1:0] CH_G       = 8'h67;
  localparam logic [CHAR_W-1:0] CH_KEY_OCT = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_P       = 8'h70;
  localparam logic [CHAR_W-1:0] CH_Z       = 8'h7A;

  localparam logic [WNT_W-1:0] WNT_LONGEST = WNT_W'(4000000);
  localparam int TONE_HZ [7] = '{440, 494, 523, 587, 659, 698, 784};

  typedef enum logic [3:0] {
    PH_TITLE, PH_DEF_KEY, PH_DEF_VALUE, PH_NOTE_START, PH_DUR_FIRST, PH_DUR_SECOND,
    PH_NOTE_LETTER, PH_SHARP, PH_DOT, PH_OCTAVE, PH_SEPARATOR
  } phase_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    logic              last;
  } note_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  char_valid = 1'b0;
  logic [CHAR_W-1:0]     char_data  = '0;
  logic                  note_ready = 1'b0;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr      = '0;
  logic [CFG_DATA_W-1:0] pwdata     = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rtnp_char_if char_if();
  rtnp_note_if note_if();

  assign char_if.valid     = char_valid;
  assign char_if.char_code = char_data;
  assign note_if.ready     = note_ready;

  ringtone_text_note_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_if),
    .note_out (note_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  phase_t            ph;
  logic [7:0]        def_dur;
  logic [OCT_W-1:0]  def_oct;
  logic [7:0]        def_key;
  logic [7:0]        acc;
  logic [7:0]        cur_dur;
  logic [OCT_W-1:0]  cur_oct;
  logic [BASE_W-1:0] cur_freq;
  logic              dotted;
  logic [WNT_W-1:0]  wnt;

  note_t notes_due[$];
  int    chars_sent  = 0;
  int    note_errors = 0;
  int    reg_errors  = 0;
  int    idle_cycles = 0;
  int    ready_hold  = 0;
  bit    steady      = 1'b0;

  function automatic void clear_parser();
    ph       = PH_TITLE;
    def_dur  = DEF_DUR_RESET;
    def_oct  = DEF_OCT_RESET;
    def_key  = '0;
    acc      = '0;
    cur_dur  = '0;
    cur_oct  = '0;
    cur_freq = '0;
    dotted   = 1'b0;
  endfunction

  function automatic bit num_char(input logic [CHAR_W-1:0] c);
    return c >= CH_DIGIT0 && c <= CH_DIGIT9;
  endfunction

  // Advances the parser by one character and reports whether a note is completed.
  function automatic bit next_note(input logic [CHAR_W-1:0] c, output note_t n);
    phase_t      st;
    int unsigned f;
    int unsigned d;
    int unsigned v;
    n  = '0;
    st = ph;
    if (st == PH_TITLE) begin
      if (c == CH_END) clear_parser();
      else if (c == CH_COLON) ph = PH_DEF_KEY;
      return 1'b0;
    end
    if (st == PH_DEF_KEY) begin
      if (c == CH_END) begin
        clear_parser();
      end else if (c == CH_COLON) begin
        ph = PH_NOTE_START;
      end else if (c >= CH_A && c <= CH_Z) begin
        def_key = c;
        acc     = '0;
        ph      = PH_DEF_VALUE;
      end
      return 1'b0;
    end
    if (st == PH_DEF_VALUE) begin
      if (c == CH_END) begin
        clear_parser();
      end else if (num_char(c)) begin
        v   = int'(acc) * 10 + int'(c) - int'(CH_DIGIT0);
        acc = (v > 255) ? 8'd255 : v[7:0];
      end else if (c == CH_COLON || c == CH_COMMA) begin
        if (def_key == CH_KEY_OCT) def_oct = (acc > 8'(OCT_MAX)) ? OCT_MAX : acc[OCT_W-1:0];
        else if (def_key == CH_KEY_DUR) def_dur = acc;
        ph = (c == CH_COLON) ? PH_NOTE_START : PH_DEF_KEY;
      end
      return 1'b0;
    end
    if (st == PH_NOTE_START) begin
      cur_dur  = def_dur;
      cur_oct  = def_oct;
      dotted   = 1'b0;
      cur_freq = '0;
      ph       = PH_DUR_FIRST;
      st       = PH_DUR_FIRST;
    end
    if (st == PH_DUR_FIRST) begin
      if (c == CH_END) begin
        clear_parser();
        return 1'b0;
      end
      if (num_char(c)) begin
        cur_dur = c - CH_DIGIT0;
        ph      = PH_DUR_SECOND;
        return 1'b0;
      end
      st = PH_DUR_SECOND;
    end
    if (st == PH_DUR_SECOND) begin
      if (num_char(c)) begin
        v       = int'(cur_dur) * 10 + int'(c) - int'(CH_DIGIT0);
        cur_dur = v[7:0];
        ph      = PH_NOTE_LETTER;
        return 1'b0;
      end
      st = PH_NOTE_LETTER;
    end
    if (st == PH_NOTE_LETTER) begin
      if (c == CH_END) begin
        clear_parser();
        return 1'b0;
      end
      cur_freq = (c >= CH_A && c <= CH_G) ? BASE_W'(TONE_HZ[c - CH_A]) : '0;
      ph       = PH_SHARP;
      return 1'b0;
    end
    if (st == PH_SHARP) begin
      if (c == CH_SHARP) begin
        f        = int'(cur_freq) * 10595 / 10000;
        cur_freq = f[BASE_W-1:0];
        ph       = PH_DOT;
        return 1'b0;
      end
      st = PH_DOT;
    end
    if (st == PH_DOT) begin
      if (c == CH_DOT) begin
        dotted = 1'b1;
        ph     = PH_OCTAVE;
        return 1'b0;
      end
      st = PH_OCTAVE;
    end
    if (st == PH_OCTAVE && num_char(c)) begin
      cur_oct = OCT_W'(c - CH_DIGIT0);
      ph      = PH_SEPARATOR;
      return 1'b0;
    end
    if (c == CH_COMMA || c == CH_END) begin
      f = cur_freq;
      if (cur_oct > OCT_BASE) f = f << (cur_oct - OCT_BASE);
      d = (cur_dur != 0) ? int'(wnt) / int'(cur_dur) : 0;
      if (dotted) d = d * 3 / 2;
      n.freq = f[FREQ_W-1:0];
      n.dur  = d[DUR_W-1:0];
      n.last = (c == CH_END);
      if (c == CH_END) clear_parser();
      else ph = PH_NOTE_START;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_duration();
    if ($urandom_range(0, 9) < 8) return 1 << $urandom_range(0, 5);
    return $urandom_range(0, 99);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      note_ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      ready_hold = steady ? 0 : pick_gap();
      note_ready <= (ready_hold == 0);
    end
  end

  always @(posedge clk) begin
    note_t want;
    if (!rst && note_if.valid && note_ready) begin
      if (notes_due.size() == 0) begin
        $error("unexpected note: frequency_hz %0d note_duration %0d last_note %0d",
               note_if.frequency_hz, note_if.note_duration, note_if.last_note);
        note_errors++;
      end else begin
        want = notes_due.pop_front();
        if (note_if.frequency_hz !== want.freq) begin
          $error("frequency_hz expected %0d actual %0d", want.freq, note_if.frequency_hz);
          note_errors++;
        end
        if (note_if.note_duration !== want.dur) begin
          $error("note_duration expected %0d actual %0d", want.dur, note_if.note_duration);
          note_errors++;
        end
        if (note_if.last_note !== want.last) begin
          $error("last_note expected %0d actual %0d", want.last, note_if.last_note);
          note_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && char_if.ready) || (note_if.valid && note_ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c);
    int    gap;
    note_t n;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= c;
    do @(posedge clk); while (!char_if.ready);
    chars_sent++;
    if (next_note(c, n)) notes_due.push_back(n);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_number(input int v);
    if (v >= 100) send_char(8'(CH_DIGIT0 + (v / 100) % 10));
    if (v >= 10) send_char(8'(CH_DIGIT0 + (v / 10) % 10));
    send_char(8'(CH_DIGIT0 + v % 10));
  endtask

  task automatic drain_notes();
    char_valid <= 1'b0;
    while (notes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_whole_note_time(input logic [WNT_W-1:0] value);
    logic [CFG_DATA_W-1:0] got;
    drain_notes();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_WNT_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    wnt = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[WNT_W-1:0] !== value) begin
      $error("whole_note_time read back expected %0d actual %0d", value, got);
      reg_errors++;
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
  endtask

  task automatic send_melody();
    int                fields;
    int                notes;
    int                r;
    logic [CHAR_W-1:0] c;
    repeat ($urandom_range(0, 4)) begin
      c = 8'($urandom_range(1, 255));
      send_char((c == CH_COLON) ? CH_Z : c);
    end
    send_char(CH_COLON);
    fields = $urandom_range(0, 3);
    for (int k = 0; k < fields; k++) begin
      if (k != 0) send_char(CH_COMMA);
      case ($urandom_range(0, 3))
        0: begin
          send_text("d=");
          send_number(pick_duration());
        end
        1: begin
          send_text("o=");
          send_number($urandom_range(3, 8));
        end
        2: begin
          send_char(CH_KEY_BPM);
          send_char(CH_EQUALS);
          send_number($urandom_range(40, 250));
        end
        default: begin
          send_char(8'($urandom_range(CH_A, CH_Z)));
          send_number($urandom_range(0, 999));
        end
      endcase
    end
    send_char(CH_COLON);
    notes = $urandom_range(1, 8);
    for (int k = 0; k < notes; k++) begin
      if (k != 0) send_char(CH_COMMA);
      if ($urandom_range(0, 2) != 0) send_number(pick_duration());
      if ($urandom_range(0, 9) < 8) begin
        r = $urandom_range(0, 7);
        send_char((r == 7) ? CH_P : 8'(CH_A + r));
      end else begin
        send_char(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 2) == 0) send_char(CH_SHARP);
      if ($urandom_range(0, 3) == 0) send_char(CH_DOT);
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 9) < 8) send_char(8'(CH_DIGIT0 + $urandom_range(4, 7)));
        else send_char(8'(CH_DIGIT0 + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 9) == 0) send_char(8'($urandom_range(1, 255)));
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      send_char(CH_END);
    end else if (r < 9) begin
      send_char(CH_COMMA);
      send_char(CH_END);
    end
  endtask

  task automatic test_header_and_special_cases();
    send_text("x:d=999,o=12:0e#.9,b");
    send_char(8'hFF);
    send_text(",z");
    send_char(CH_END);
  endtask

  task automatic test_end_with_nothing_pending();
    send_char(CH_END);
    send_text("::4");
    send_char(CH_END);
  endtask

  task automatic test_random_melodies(input logic [WNT_W-1:0] whole, input bit no_idle);
    int stop_at;
    write_whole_note_time(whole);
    steady  = no_idle;
    stop_at = chars_sent + RANDOM_CHARS_PER_PHASE;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_melody();
    end
    steady = 1'b0;
  endtask

  initial begin
    clear_parser();
    wnt = WNT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_header_and_special_cases();
    test_end_with_nothing_pending();
    test_random_melodies(WNT_LONGEST, 1'b0);
    test_random_melodies(WNT_W'(1), 1'b1);
    test_random_melodies(WNT_W'($urandom_range(1, 4000000)), 1'b0);
    test_random_melodies(WNT_W'($urandom_range(2, 5000)), 1'b0);
    drain_notes();
    if (note_errors == 0 && reg_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
